FILE: rtl/can_rxq_pkg.sv
package can_rxq_pkg;

   // Field widths of the frame and of the status words.
   localparam int ID_W   = 29;
   localparam int DLC_W  = 4;
   localparam int DATA_W = 64;
   localparam int CNT_W  = 9;
   localparam int IDX_W  = 3;

   // Defaults of the top-level parameters.
   localparam int DEF_QUEUE_DEPTH = 16;
   localparam int DEF_NUM_FILTERS = 3;

   // Number of filter register sets that the register map provides.
   localparam int FILTER_SLOTS = 3;

   // Command queue between the front and the back end.
   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

   // Command codes on the request channel.
   localparam logic [1:0] CMD_RECEIVE  = 2'd0;
   localparam logic [1:0] CMD_DISPATCH = 2'd1;
   localparam logic [1:0] CMD_ERROR    = 2'd2;

   // Bus error types.
   localparam logic [7:0] ERRT_STUFF = 8'd0;
   localparam logic [7:0] ERRT_CRC   = 8'd1;
   localparam logic [7:0] ERRT_FORM  = 8'd2;

   // Result kinds.
   localparam logic [1:0] KIND_RX_STATUS = 2'd0;
   localparam logic [1:0] KIND_FRAME     = 2'd1;
   localparam logic [1:0] KIND_EMPTY     = 2'd2;
   localparam logic [1:0] KIND_ERROR     = 2'd3;

   // Bus states.
   localparam logic [1:0] BUS_ACTIVE  = 2'd0;
   localparam logic [1:0] BUS_WARNING = 2'd1;
   localparam logic [1:0] BUS_PASSIVE = 2'd2;
   localparam logic [1:0] BUS_OFF     = 2'd3;

   // Register map.
   localparam logic [IDX_W-1:0] REG_F0_ID     = 3'd0;
   localparam logic [IDX_W-1:0] REG_F0_MASK   = 3'd1;
   localparam logic [IDX_W-1:0] REG_F1_ID     = 3'd2;
   localparam logic [IDX_W-1:0] REG_F1_MASK   = 3'd3;
   localparam logic [IDX_W-1:0] REG_F2_ID     = 3'd4;
   localparam logic [IDX_W-1:0] REG_F2_MASK   = 3'd5;
   localparam logic [IDX_W-1:0] REG_ENABLE    = 3'd6;

   // Length code limit and error counter constants.
   localparam logic [DLC_W-1:0] DLC_MAX  = 4'd8;
   localparam logic [CNT_W-1:0] CNT_MAX  = 9'd511;
   localparam logic [CNT_W-1:0] ERR_STEP = 9'd8;
   localparam logic [CNT_W-1:0] LIM_OFF  = 9'd255;
   localparam logic [CNT_W-1:0] LIM_PASS = 9'd127;
   localparam logic [CNT_W-1:0] LIM_WARN = 9'd96;

   typedef enum logic [1:0] {
      OP_RECEIVE,
      OP_DISPATCH,
      OP_ERROR
   } op_type;

   typedef enum logic [1:0] {
      ERR_NONE,
      ERR_TX,
      ERR_RX
   } err_type;

   typedef struct packed {
      logic              ext;
      logic [DLC_W-1:0]  dlc;
      logic [ID_W-1:0]   id;
      logic [DATA_W-1:0] data;
   } frame_type;

   typedef struct packed {
      op_type    op;
      err_type   err;
      frame_type frame;
   } cmd_entry_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic              dropped;
      logic [ID_W-1:0]   id;
      logic [DLC_W-1:0]  dlc;
      logic [DATA_W-1:0] data;
      logic              ext;
      logic [FILTER_SLOTS-1:0] match;
      logic              last;
      logic [1:0]        bus;
      logic [CNT_W-1:0]  tx;
      logic [CNT_W-1:0]  rx;
   } rsp_type;

   function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] c);
      logic [CNT_W:0] s;
      s = {1'b0, c} + {1'b0, ERR_STEP};
      return (s > {1'b0, CNT_MAX}) ? CNT_MAX : s[CNT_W-1:0];
   endfunction

   function automatic logic [1:0] bus_state_of(input logic [CNT_W-1:0] tx,
                                               input logic [CNT_W-1:0] rx);
      logic [1:0] st;
      if (tx > LIM_OFF || rx > LIM_OFF) begin
         st = BUS_OFF;
      end else if (tx > LIM_PASS || rx > LIM_PASS) begin
         st = BUS_PASSIVE;
      end else if (tx > LIM_WARN || rx > LIM_WARN) begin
         st = BUS_WARNING;
      end else begin
         st = BUS_ACTIVE;
      end
      return st;
   endfunction

endpackage

FILE: rtl/can_rxq_if.sv
interface can_rxq_req_if import can_rxq_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        command;
   logic [ID_W-1:0]   frame_id;
   logic [DLC_W-1:0]  frame_dlc;
   logic [DATA_W-1:0] frame_data;
   logic              frame_extended;
   logic [7:0]        error_type;

   modport source (output valid, command, frame_id, frame_dlc, frame_data,
                   frame_extended, error_type, input ready);
   modport sink (input valid, command, frame_id, frame_dlc, frame_data,
                 frame_extended, error_type, output ready);
endinterface

interface can_rxq_rsp_if import can_rxq_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [1:0]              kind;
   logic                    frame_dropped;
   logic [ID_W-1:0]         out_id;
   logic [DLC_W-1:0]        out_dlc;
   logic [DATA_W-1:0]       out_data;
   logic                    out_extended;
   logic [FILTER_SLOTS-1:0] match_mask;
   logic                    last;
   logic [1:0]              bus_state;
   logic [CNT_W-1:0]        tx_error_count;
   logic [CNT_W-1:0]        rx_error_count;

   modport source (output valid, kind, frame_dropped, out_id, out_dlc, out_data,
                   out_extended, match_mask, last, bus_state, tx_error_count,
                   rx_error_count, input ready);
   modport sink (input valid, kind, frame_dropped, out_id, out_dlc, out_data,
                 out_extended, match_mask, last, bus_state, tx_error_count,
                 rx_error_count, output ready);
endinterface

interface can_rxq_csr_if import can_rxq_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] index;
   logic [ID_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/can_rxq_front.sv
module can_rxq_front import can_rxq_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   can_rxq_req_if.sink    req,
   output cmd_entry_type  cmd,
   output logic           cmd_valid,
   input  logic           cmd_pop
);

   cmd_entry_type             entry_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0]     wr_ff, wr_in;
   logic [CMDQ_PTR_W-1:0]     rd_ff, rd_in;
   logic [CMDQ_CNT_W-1:0]     count_ff, count_in;
   logic                      accept;
   logic                      push;
   cmd_entry_type             decoded;

   assign req.ready = (count_ff != CMDQ_CNT_W'(CMDQ_DEPTH));
   assign accept    = req.valid && req.ready;
   assign cmd       = entry_ff[rd_ff];
   assign cmd_valid = (count_ff != '0);

   // Classify the beat; an unknown command is dropped here.
   always_comb begin
      push                 = accept;
      decoded.op           = OP_RECEIVE;
      decoded.err          = ERR_NONE;
      decoded.frame.id     = req.frame_id;
      decoded.frame.data   = req.frame_data;
      decoded.frame.ext    = req.frame_extended;
      decoded.frame.dlc    = (req.frame_dlc > DLC_MAX) ? DLC_MAX : req.frame_dlc;
      case (req.command)
         CMD_RECEIVE:  decoded.op = OP_RECEIVE;
         CMD_DISPATCH: decoded.op = OP_DISPATCH;
         CMD_ERROR:    decoded.op = OP_ERROR;
         default:      push = 1'b0;
      endcase
      case (req.error_type) inside
         ERRT_STUFF:           decoded.err = ERR_TX;
         ERRT_CRC, ERRT_FORM:  decoded.err = ERR_RX;
         default:              decoded.err = ERR_NONE;
      endcase
   end

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (cmd_pop) begin
         rd_in = (rd_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !cmd_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && cmd_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= decoded;
      end
   end

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("command queue popped while empty");

endmodule

FILE: rtl/can_rxq_filter.sv
module can_rxq_filter import can_rxq_pkg::*; #(
   parameter int NUM_FILTERS = DEF_NUM_FILTERS
) (
   input  logic                    clock,
   input  logic                    reset,
   can_rxq_csr_if.sink             csr,
   input  logic [ID_W-1:0]         frame_id,
   output logic [FILTER_SLOTS-1:0] match
);

   logic [ID_W-1:0]         id_ff   [FILTER_SLOTS];
   logic [ID_W-1:0]         mask_ff [FILTER_SLOTS];
   logic [FILTER_SLOTS-1:0] enable_ff;
   logic                    write;

   assign csr.ready = 1'b1;
   assign write     = csr.valid && csr.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FILTER_SLOTS; i++) begin
            id_ff[i]   <= '0;
            mask_ff[i] <= '0;
         end
         enable_ff <= '0;
      end else if (write) begin
         case (csr.index)
            REG_F0_ID:   id_ff[0]   <= csr.data;
            REG_F0_MASK: mask_ff[0] <= csr.data;
            REG_F1_ID:   id_ff[1]   <= csr.data;
            REG_F1_MASK: mask_ff[1] <= csr.data;
            REG_F2_ID:   id_ff[2]   <= csr.data;
            REG_F2_MASK: mask_ff[2] <= csr.data;
            REG_ENABLE:  enable_ff  <= csr.data[FILTER_SLOTS-1:0];
            default:     ;
         endcase
      end
   end

   // A zero mask with a zero id accepts everything; with a nonzero id it
   // asks for an exact match.
   always_comb begin
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < FILTER_SLOTS; i++) begin
         if (mask_ff[i] != '0) begin
            hit = ((frame_id & mask_ff[i]) == (id_ff[i] & mask_ff[i]));
         end else if (id_ff[i] != '0) begin
            hit = (frame_id == id_ff[i]);
         end else begin
            hit = 1'b1;
         end
         match[i] = enable_ff[i] && (i < NUM_FILTERS) && hit;
      end
   end

endmodule

FILE: rtl/can_rxq_back.sv
module can_rxq_back import can_rxq_pkg::*; #(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_entry_type           cmd,
   input  logic                    cmd_valid,
   output logic                    cmd_pop,
   output logic [ID_W-1:0]         filt_id,
   input  logic [FILTER_SLOTS-1:0] filt_match,
   can_rxq_rsp_if.source           rsp
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_OUT  = 2'd2;

   frame_type        queue_mem [QUEUE_DEPTH];
   frame_type        rd_q_ff;
   logic [1:0]       state_ff, state_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_next, rd_next;
   logic [CNT_W-1:0] tx_ff, tx_in, tx_new;
   logic [CNT_W-1:0] rx_ff, rx_in, rx_new;
   logic [1:0]       link_ff, link_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   logic             mem_we;

   assign wr_next = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_next = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
   assign filt_id = rd_q_ff.id;

   always_comb begin
      tx_new = tx_ff;
      rx_new = rx_ff;
      case (cmd.err)
         ERR_TX:  tx_new = sat_add(tx_ff);
         ERR_RX:  rx_new = sat_add(rx_ff);
         default: ;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      tx_in        = tx_ff;
      rx_in        = rx_ff;
      link_in      = link_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      cmd_pop      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               rsp_in      = '0;
               rsp_in.last = 1'b1;
               rsp_in.bus  = link_ff;
               rsp_in.tx   = tx_ff;
               rsp_in.rx   = rx_ff;
               case (cmd.op)
                  OP_RECEIVE: begin
                     rsp_in.kind    = KIND_RX_STATUS;
                     rsp_in.dropped = (wr_next == rd_ptr_ff);
                     if (wr_next != rd_ptr_ff) begin
                        mem_we    = 1'b1;
                        wr_ptr_in = wr_next;
                     end
                     rsp_valid_in = 1'b1;
                     state_in     = S_OUT;
                  end
                  OP_DISPATCH: begin
                     if (rd_ptr_ff == wr_ptr_ff) begin
                        rsp_in.kind  = KIND_EMPTY;
                        rsp_valid_in = 1'b1;
                        state_in     = S_OUT;
                     end else begin
                        state_in = S_READ;
                     end
                  end
                  OP_ERROR: begin
                     tx_in        = tx_new;
                     rx_in        = rx_new;
                     link_in      = bus_state_of(tx_new, rx_new);
                     rsp_in.kind  = KIND_ERROR;
                     rsp_in.bus   = bus_state_of(tx_new, rx_new);
                     rsp_in.tx    = tx_new;
                     rsp_in.rx    = rx_new;
                     rsp_valid_in = 1'b1;
                     state_in     = S_OUT;
                  end
                  default: ;
               endcase
            end
         end
         S_READ: begin
            rsp_in.kind    = KIND_FRAME;
            rsp_in.dropped = 1'b0;
            rsp_in.id      = rd_q_ff.id;
            rsp_in.dlc     = rd_q_ff.dlc;
            rsp_in.data    = rd_q_ff.data;
            rsp_in.ext     = rd_q_ff.ext;
            rsp_in.match   = filt_match;
            rsp_in.last    = (rd_next == wr_ptr_ff);
            rsp_in.bus     = link_ff;
            rsp_in.tx      = tx_ff;
            rsp_in.rx      = rx_ff;
            rd_ptr_in      = rd_next;
            rsp_valid_in   = 1'b1;
            state_in       = S_OUT;
         end
         S_OUT: begin
            if (rsp.ready) begin
               rsp_valid_in = 1'b0;
               state_in     = rsp_ff.last ? S_IDLE : S_READ;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         tx_ff        <= '0;
         rx_ff        <= '0;
         link_ff      <= BUS_ACTIVE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         tx_ff        <= tx_in;
         rx_ff        <= rx_in;
         link_ff      <= link_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // Frame store with a registered read port at the read pointer.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         queue_mem[wr_ptr_ff] <= cmd.frame;
      end
      rd_q_ff <= queue_mem[rd_ptr_ff];
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.kind           = rsp_ff.kind;
   assign rsp.frame_dropped  = rsp_ff.dropped;
   assign rsp.out_id         = rsp_ff.id;
   assign rsp.out_dlc        = rsp_ff.dlc;
   assign rsp.out_data       = rsp_ff.data;
   assign rsp.out_extended   = rsp_ff.ext;
   assign rsp.match_mask     = rsp_ff.match;
   assign rsp.last           = rsp_ff.last;
   assign rsp.bus_state      = rsp_ff.bus;
   assign rsp.tx_error_count = rsp_ff.tx;
   assign rsp.rx_error_count = rsp_ff.rx;

   a_valid_in_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff == (state_ff == S_OUT))
      else $error("result valid out of step with the output state");

   a_last_drains: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.kind == KIND_FRAME && rsp_ff.last |->
      rd_ptr_ff == wr_ptr_ff)
      else $error("last frame given while the queue still holds frames");

   a_cnt_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> tx_ff >= $past(tx_ff) && rx_ff >= $past(rx_ff))
      else $error("error counter decreased");

endmodule

FILE: rtl/can_rx_filter_queue_error_state.sv
// A receive or bus error beat passes through the command queue and the back-end
// sequencer into the output register. A dispatch reads each frame through the
// registered read port of the frame store and reads the next one after the previous one is taken.
// The back-end sequencer pops no new command until the receiver has taken the last result.
// Reset clears pointers, error counters, bus state, filters and the command queue;
// the frame store is not cleared and needs no clearing pass.
module can_rx_filter_queue_error_state import can_rxq_pkg::*; #(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
   parameter int NUM_FILTERS = DEF_NUM_FILTERS
) (
   input  logic          clock,
   input  logic          reset,
   can_rxq_req_if.sink   req_bus,
   can_rxq_rsp_if.source rsp_bus,
   can_rxq_csr_if.sink   csr_bus
);

   // The front end decodes each request beat, clamps the length code and sorts
   // the error type, then parks the command in a two-entry queue. Unknown
   // commands are dropped there and never reach the back end.
   cmd_entry_type           cmd;
   logic                    cmd_valid;
   logic                    cmd_pop;
   logic [ID_W-1:0]         filt_id;
   logic [FILTER_SLOTS-1:0] filt_match;

   can_rxq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop)
   );

   // The filter bank holds the acceptance registers written over the register
   // port and works out the match mask for the frame being read out.
   can_rxq_filter #(
      .NUM_FILTERS (NUM_FILTERS)
   ) u_filter (
      .clock    (clock),
      .reset    (reset),
      .csr      (csr_bus),
      .frame_id (filt_id),
      .match    (filt_match)
   );

   // The back end owns the frame ring, the error counters and the output
   // register. It keeps one slot of the ring free, so a full ring holds one
   // frame fewer than its depth, and a dispatch walks the ring one beat at a
   // time until the read pointer meets the write pointer.
   can_rxq_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .cmd_valid  (cmd_valid),
      .cmd_pop    (cmd_pop),
      .filt_id    (filt_id),
      .filt_match (filt_match),
      .rsp        (rsp_bus)
   );

endmodule

FILE: test/can_rx_filter_queue_error_state_tb.sv
module can_rx_filter_queue_error_state_tb import can_rxq_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   // The command set has a fourth code that the block must swallow without a result.
   localparam logic [1:0] CMD_UNKNOWN = 2'd3;

   localparam int RXQ_SLOTS   = DEF_QUEUE_DEPTH;
   localparam int FILTERS     = DEF_NUM_FILTERS;
   localparam int SETTLE      = 8;
   localparam int DRAIN_WAIT  = 16;
   localparam int HOLD_CYCLES = 400;
   localparam int CYCLE_LIMIT = 400000;
   localparam int REPORT_MAX  = 10;

   // One request beat as the sender sees it.
   typedef struct packed {
      logic [1:0]        cmd;
      logic [ID_W-1:0]   id;
      logic [DLC_W-1:0]  dlc;
      logic [DATA_W-1:0] data;
      logic              ext;
      logic [7:0]        err;
   } can_beat_type;

   // A row of the directed table. Where typed is set, the single result of the row is
   // given here by hand; every other row is left to the predictor.
   typedef struct packed {
      logic [1:0]        cmd;
      logic [ID_W-1:0]   id;
      logic [DLC_W-1:0]  dlc;
      logic [DATA_W-1:0] data;
      logic              ext;
      logic [7:0]        err;
      logic              typed;
      logic [1:0]        x_kind;
      logic              x_drop;
      logic [1:0]        x_bus;
      logic [CNT_W-1:0]  x_tx;
      logic [CNT_W-1:0]  x_rx;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset;

   can_rxq_req_if req_bus ();
   can_rxq_rsp_if rsp_bus ();
   can_rxq_csr_if csr_bus ();

   can_rx_filter_queue_error_state DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Shadow state of the receive path: the ring of frames, its two pointers, the error
   // counters with the bus state, and the filter registers as last written.
   frame_type         rxq_frames [RXQ_SLOTS];
   int unsigned       rxq_wr;
   int unsigned       rxq_rd;
   logic [CNT_W-1:0]  tx_count;
   logic [CNT_W-1:0]  rx_count;
   logic [1:0]        bus_now;
   logic [ID_W-1:0]   flt_id   [FILTERS];
   logic [ID_W-1:0]   flt_mask [FILTERS];
   logic [2:0]        flt_enable;

   // Results still owed by the block, oldest first.
   rsp_type rx_path_results [$];

   int req_idle_pct;
   int rsp_idle_pct;
   int items_sent;
   int mismatch_count = 0;
   int cycle_count    = 0;
   bit start_hold;
   int hold_left      = 0;
   bit hold_done      = 1'b0;

   // The directed part. It opens on an empty queue with both counters at zero, so the
   // status beats can be written down directly. Frames carry extreme ids, a length code
   // above eight that must be stored as eight, and both id formats. Error beats walk
   // through stuff, crc, form and three ignored types; the unknown command appears twice,
   // once with a stuff error type that must not count.
   directed_row_type directed_rows [21] = '{
      '{CMD_DISPATCH, 29'h0, 4'd0, 64'h0, 1'b0, 8'd0,
        1'b1, KIND_EMPTY, 1'b0, BUS_ACTIVE, 9'd0, 9'd0},
      '{CMD_ERROR, 29'h0, 4'd0, 64'h0, 1'b0, 8'd255,
        1'b1, KIND_ERROR, 1'b0, BUS_ACTIVE, 9'd0, 9'd0},
      '{CMD_ERROR, 29'h1FFFFFFF, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 8'd3,
        1'b1, KIND_ERROR, 1'b0, BUS_ACTIVE, 9'd0, 9'd0},
      '{CMD_UNKNOWN, 29'h1FFFFFFF, 4'd8, 64'hDEAD_BEEF_0000_FFFF, 1'b1, 8'd1,
        1'b0, KIND_RX_STATUS, 1'b0, BUS_ACTIVE, 9'd0, 9'd0},
      '{CMD_RECEIVE, 29'h0, 4'd0, 64'h0, 1'b0, 8'd0,
        1'b1, KIND_RX_STATUS, 1'b0, BUS_ACTIVE, 9'd0, 9'd0},
      '{CMD_RECEIVE, 29'h1FFFFFFF, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 8'd255,
        1'b1, KIND_RX_STATUS, 1'b0, BUS_ACTIVE, 9'd0, 9'd0},
      '{CMD_RECEIVE, 29'h123, 4'd8, 64'h0123_4567_89AB_CDEF, 1'b0, 8'd0,
        1'b1, KIND_RX_STATUS, 1'b0, BUS_ACTIVE, 9'd0, 9'd0},
      '{CMD_RECEIVE, 29'h1ABCD123, 4'd9, 64'hFEDC_BA98_7654_3210, 1'b1, 8'd2,
        1'b1, KIND_RX_STATUS, 1'b0, BUS_ACTIVE, 9'd0, 9'd0},
      '{CMD_RECEIVE, 29'h7FF, 4'd1, 64'h0000_0000_0000_00A5, 1'b0, 8'd0,
        1'b1, KIND_RX_STATUS, 1'b0, BUS_ACTIVE, 9'd0, 9'd0},
      '{CMD_DISPATCH, 29'h0, 4'd0, 64'h0, 1'b0, 8'd0,
        1'b0, KIND_FRAME, 1'b0, BUS_ACTIVE, 9'd0, 9'd0},
      '{CMD_DISPATCH, 29'h0, 4'd0, 64'h0, 1'b0, 8'd0,
        1'b1, KIND_EMPTY, 1'b0, BUS_ACTIVE, 9'd0, 9'd0},
      '{CMD_ERROR, 29'h0, 4'd0, 64'h0, 1'b0, ERRT_STUFF,
        1'b1, KIND_ERROR, 1'b0, BUS_ACTIVE, 9'd8, 9'd0},
      '{CMD_ERROR, 29'h0, 4'd0, 64'h0, 1'b0, ERRT_CRC,
        1'b1, KIND_ERROR, 1'b0, BUS_ACTIVE, 9'd8, 9'd8},
      '{CMD_ERROR, 29'h0, 4'd0, 64'h0, 1'b0, ERRT_FORM,
        1'b1, KIND_ERROR, 1'b0, BUS_ACTIVE, 9'd8, 9'd16},
      '{CMD_ERROR, 29'h0, 4'd0, 64'h0, 1'b0, 8'h80,
        1'b1, KIND_ERROR, 1'b0, BUS_ACTIVE, 9'd8, 9'd16},
      '{CMD_RECEIVE, 29'h0AAAAAAA, 4'd4, 64'h5555_5555_5555_5555, 1'b0, 8'd0,
        1'b1, KIND_RX_STATUS, 1'b0, BUS_ACTIVE, 9'd8, 9'd16},
      '{CMD_RECEIVE, 29'h15555555, 4'd7, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 8'd0,
        1'b1, KIND_RX_STATUS, 1'b0, BUS_ACTIVE, 9'd8, 9'd16},
      '{CMD_UNKNOWN, 29'h0, 4'd0, 64'h0, 1'b0, ERRT_STUFF,
        1'b0, KIND_RX_STATUS, 1'b0, BUS_ACTIVE, 9'd0, 9'd0},
      '{CMD_DISPATCH, 29'h0, 4'd0, 64'h0, 1'b0, 8'd0,
        1'b0, KIND_FRAME, 1'b0, BUS_ACTIVE, 9'd0, 9'd0},
      '{CMD_RECEIVE, 29'h1FFFFFFF, 4'd0, 64'h0, 1'b0, 8'd0,
        1'b1, KIND_RX_STATUS, 1'b0, BUS_ACTIVE, 9'd8, 9'd16},
      '{CMD_DISPATCH, 29'h0, 4'd0, 64'h0, 1'b0, 8'd0,
        1'b0, KIND_FRAME, 1'b0, BUS_ACTIVE, 9'd0, 9'd0}
   };

   // A status beat carries the counters and bus state as they stand, all else zero.
   function automatic rsp_type status_beat(input logic [1:0] kind);
      rsp_type r;
      r      = '0;
      r.kind = kind;
      r.bus  = bus_now;
      r.tx   = tx_count;
      r.rx   = rx_count;
      return r;
   endfunction

   // Mask of the enabled filters that accept an id. A nonzero mask compares the masked
   // bits; a zero mask with a nonzero id wants the exact id; both zero accept anything.
   function automatic logic [FILTER_SLOTS-1:0] filter_hits(input logic [ID_W-1:0] id);
      logic [FILTER_SLOTS-1:0] hits;
      logic                    ok;
      hits = '0;
      for (int i = 0; i < FILTERS; i++) begin
         if (flt_enable[i]) begin
            ok = 1'b1;
            if (flt_mask[i] != '0) begin
               ok = (id & flt_mask[i]) == (flt_id[i] & flt_mask[i]);
            end else if (flt_id[i] != '0) begin
               ok = (id == flt_id[i]);
            end
            if (ok) begin
               hits[i] = 1'b1;
            end
         end
      end
      return hits;
   endfunction

   function automatic logic [CNT_W-1:0] bump_count(input logic [CNT_W-1:0] c);
      return (c > CNT_MAX - ERR_STEP) ? CNT_MAX : c + ERR_STEP;
   endfunction

   // Works out what one accepted request beat must produce and queues it.
   task automatic predict_rx_path(input can_beat_type b);
      rsp_type     r;
      frame_type   fr;
      int unsigned nxt;
      case (b.cmd)
         CMD_RECEIVE: begin
            nxt = (rxq_wr + 1) % RXQ_SLOTS;
            r   = status_beat(KIND_RX_STATUS);
            if (nxt == rxq_rd) begin
               r.dropped = 1'b1;
            end else begin
               fr.id   = b.id;
               fr.dlc  = (b.dlc > DLC_MAX) ? DLC_MAX : b.dlc;
               fr.data = b.data;
               fr.ext  = b.ext;
               rxq_frames[rxq_wr] = fr;
               rxq_wr = nxt;
            end
            r.last = 1'b1;
            rx_path_results.push_back(r);
         end
         CMD_DISPATCH: begin
            if (rxq_rd == rxq_wr) begin
               r      = status_beat(KIND_EMPTY);
               r.last = 1'b1;
               rx_path_results.push_back(r);
            end
            while (rxq_rd != rxq_wr) begin
               fr      = rxq_frames[rxq_rd];
               r       = status_beat(KIND_FRAME);
               r.id    = fr.id;
               r.dlc   = fr.dlc;
               r.data  = fr.data;
               r.ext   = fr.ext;
               r.match = filter_hits(fr.id);
               rxq_rd  = (rxq_rd + 1) % RXQ_SLOTS;
               r.last  = (rxq_rd == rxq_wr);
               rx_path_results.push_back(r);
            end
         end
         CMD_ERROR: begin
            if (b.err == ERRT_STUFF) begin
               tx_count = bump_count(tx_count);
            end else if (b.err == ERRT_CRC || b.err == ERRT_FORM) begin
               rx_count = bump_count(rx_count);
            end
            // The bus state is re-evaluated on every error beat, ignored types too.
            if (tx_count > LIM_OFF || rx_count > LIM_OFF) begin
               bus_now = BUS_OFF;
            end else if (tx_count > LIM_PASS || rx_count > LIM_PASS) begin
               bus_now = BUS_PASSIVE;
            end else if (tx_count > LIM_WARN || rx_count > LIM_WARN) begin
               bus_now = BUS_WARNING;
            end else begin
               bus_now = BUS_ACTIVE;
            end
            r      = status_beat(KIND_ERROR);
            r.last = 1'b1;
            rx_path_results.push_back(r);
         end
         default: begin
         end
      endcase
   endtask

   // Offers one request beat after a random gap and returns at the edge that takes it.
   // Valid is only lowered when a gap follows, so back-to-back beats keep it high.
   task automatic issue_beat(input can_beat_type b);
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.command        <= b.cmd;
      req_bus.frame_id       <= b.id;
      req_bus.frame_dlc      <= b.dlc;
      req_bus.frame_data     <= b.data;
      req_bus.frame_extended <= b.ext;
      req_bus.error_type     <= b.err;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predict_rx_path(b);
      if (b.cmd != CMD_UNKNOWN) begin
         items_sent++;
      end
   endtask

   task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [ID_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      case (idx)
         REG_F0_ID:   flt_id[0]   = value;
         REG_F0_MASK: flt_mask[0] = value;
         REG_F1_ID:   flt_id[1]   = value;
         REG_F1_MASK: flt_mask[1] = value;
         REG_F2_ID:   flt_id[2]   = value;
         REG_F2_MASK: flt_mask[2] = value;
         REG_ENABLE:  flt_enable  = value[2:0];
         default: begin
         end
      endcase
   endtask

   // Rewrites the whole register map; only called while the block is idle.
   task automatic load_filters(input logic [ID_W-1:0] id0, input logic [ID_W-1:0] m0,
                               input logic [ID_W-1:0] id1, input logic [ID_W-1:0] m1,
                               input logic [ID_W-1:0] id2, input logic [ID_W-1:0] m2,
                               input logic [2:0] en);
      write_reg(REG_F0_ID, id0);
      write_reg(REG_F0_MASK, m0);
      write_reg(REG_F1_ID, id1);
      write_reg(REG_F1_MASK, m1);
      write_reg(REG_F2_ID, id2);
      write_reg(REG_F2_MASK, m2);
      write_reg(REG_ENABLE, {{(ID_W-3){1'b0}}, en});
      csr_bus.valid <= 1'b0;
   endtask

   // Waits until every owed result has come back, then waits out the settle time as well,
   // since an unknown command may still be in flight without owing anything.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (rx_path_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE) @(posedge clock);
   endtask

   // Ids are drawn so that the filters get hit: exact copies of a filter id, copies
   // with the don't-care bits scrambled, standard 11-bit ids, and fully random ones.
   function automatic logic [ID_W-1:0] pick_frame_id();
      int              f;
      logic [ID_W-1:0] r;
      f = $urandom_range(FILTERS - 1);
      r = ID_W'($urandom);
      case ($urandom_range(9))
         0, 1:    return flt_id[f];
         2, 3:    return (flt_id[f] & flt_mask[f]) | (r & ~flt_mask[f]);
         4, 5:    return r & 29'h7FF;
         default: return r;
      endcase
   endfunction

   function automatic can_beat_type random_beat(input logic [1:0] cmd);
      can_beat_type b;
      b.cmd  = cmd;
      b.id   = pick_frame_id();
      b.dlc  = ($urandom_range(7) == 0) ? DLC_W'($urandom_range(15, 9))
                                        : DLC_W'($urandom_range(8));
      b.data = {$urandom, $urandom};
      b.ext  = 1'($urandom_range(1));
      // Stuff errors dominate so that the transmit counter climbs through every bus
      // state and reaches saturation; crc and form push the receive counter along.
      case ($urandom_range(19))
         0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12: b.err = ERRT_STUFF;
         13, 14:                                   b.err = ERRT_CRC;
         15, 16:                                   b.err = ERRT_FORM;
         default:                                  b.err = 8'($urandom_range(255, 3));
      endcase
      return b;
   endfunction

   // Random traffic built from episodes. Most episodes are a burst of frames closed by
   // a dispatch, with error beats and the odd unknown command mixed in; now and then a
   // burst is long enough to overflow the queue. The rest are runs of bus errors.
   task automatic run_random(input int count);
      int target;
      int n;
      target = items_sent + count;
      while (items_sent < target) begin
         if ($urandom_range(9) < 6) begin
            n = ($urandom_range(5) == 0) ? $urandom_range(20, 12) : $urandom_range(4);
            repeat (n) begin
               issue_beat(random_beat(CMD_RECEIVE));
               if ($urandom_range(4) == 0) begin
                  issue_beat(random_beat(CMD_ERROR));
               end
               if ($urandom_range(24) == 0) begin
                  issue_beat(random_beat(CMD_UNKNOWN));
               end
            end
            issue_beat(random_beat(CMD_DISPATCH));
         end else begin
            repeat ($urandom_range(12, 1)) issue_beat(random_beat(CMD_ERROR));
         end
      end
   endtask

   // Receiver side. Ready is redrawn every cycle from the current idle rate, except
   // during a hold-off, when it stays low for a long stretch so that the block fills
   // up and has to push back on its request channel.
   always @(posedge clock) begin
      if (start_hold && !hold_done) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   function automatic string rsp_text(input rsp_type r);
      return $sformatf({"kind=%0d drop=%0d id=%h dlc=%0d data=%h ext=%0d match=%b ",
                        "last=%0d bus=%0d tx=%0d rx=%0d"},
                       r.kind, r.dropped, r.id, r.dlc, r.data, r.ext, r.match,
                       r.last, r.bus, r.tx, r.rx);
   endfunction

   // Every result beat is held against the oldest owed result, all fields at once.
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got.kind    = rsp_bus.kind;
         got.dropped = rsp_bus.frame_dropped;
         got.id      = rsp_bus.out_id;
         got.dlc     = rsp_bus.out_dlc;
         got.data    = rsp_bus.out_data;
         got.ext     = rsp_bus.out_extended;
         got.match   = rsp_bus.match_mask;
         got.last    = rsp_bus.last;
         got.bus     = rsp_bus.bus_state;
         got.tx      = rsp_bus.tx_error_count;
         got.rx      = rsp_bus.rx_error_count;
         if (rx_path_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX) begin
               $display("cycle %0d: result beat with nothing owed: %s",
                        cycle_count, rsp_text(got));
            end
         end else begin
            want = rx_path_results.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX) begin
                  $display("cycle %0d: result beat differs", cycle_count);
                  $display("   expected %s", rsp_text(want));
                  $display("   actual   %s", rsp_text(got));
               end
            end
         end
      end
   end

   // Watchdog: far beyond the slowest correct run, including the long hold-off.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      can_beat_type     b;
      directed_row_type row;
      rsp_type          typed_rsp;

      rxq_wr         = 0;
      rxq_rd         = 0;
      tx_count       = '0;
      rx_count       = '0;
      bus_now        = BUS_ACTIVE;
      flt_id         = '{default: '0};
      flt_mask       = '{default: '0};
      flt_enable     = '0;
      items_sent     = 0;
      start_hold     = 1'b0;
      req_idle_pct   = 29;
      rsp_idle_pct   = 61;

      reset                  <= 1'b1;
      req_bus.valid          <= 1'b0;
      req_bus.command        <= CMD_RECEIVE;
      req_bus.frame_id       <= '0;
      req_bus.frame_dlc      <= '0;
      req_bus.frame_data     <= '0;
      req_bus.frame_extended <= 1'b0;
      req_bus.error_type     <= ERRT_STUFF;
      csr_bus.valid          <= 1'b0;
      csr_bus.index          <= REG_F0_ID;
      csr_bus.data           <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // First setting: filter zero matches standard id 0x123 through an 11-bit mask,
      // filter one wants the all-ones id exactly, filter two accepts every frame.
      load_filters(29'h123, 29'h7FF, 29'h1FFFFFFF, 29'h0, 29'h0, 29'h0, 3'b111);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         b   = '{row.cmd, row.id, row.dlc, row.data, row.ext, row.err};
         issue_beat(b);
         if (row.typed) begin
            typed_rsp         = '0;
            typed_rsp.kind    = row.x_kind;
            typed_rsp.dropped = row.x_drop;
            typed_rsp.last    = 1'b1;
            typed_rsp.bus     = row.x_bus;
            typed_rsp.tx      = row.x_tx;
            typed_rsp.rx      = row.x_rx;
            rx_path_results[rx_path_results.size() - 1] = typed_rsp;
         end
      end
      wait_idle();

      // Random filters, some with a zero mask so that exact matching is exercised.
      load_filters(ID_W'($urandom), ($urandom_range(2) == 0) ? 29'h0 : 29'($urandom),
                   ID_W'($urandom), ($urandom_range(2) == 0) ? 29'h0 : 29'($urandom),
                   ID_W'($urandom), ($urandom_range(2) == 0) ? 29'h0 : 29'($urandom),
                   3'($urandom_range(7, 1)));
      run_random(45);
      wait_idle();

      // Swap the idle rates and move the filters to their extremes: full masks on the
      // all-zero and all-ones ids, and an exact match on the all-ones id.
      req_idle_pct = 61;
      rsp_idle_pct = 29;
      load_filters(29'h0, 29'h1FFFFFFF, 29'h1FFFFFFF, 29'h1FFFFFFF,
                   29'h1FFFFFFF, 29'h0, 3'b111);
      run_random(45);
      wait_idle();

      // No idling from here on. With every filter switched off no frame may match.
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      load_filters(ID_W'($urandom), ID_W'($urandom), ID_W'($urandom), ID_W'($urandom),
                   ID_W'($urandom), ID_W'($urandom), 3'b000);
      run_random(45);
      wait_idle();

      // Last setting, then the back-pressure test: the receiver holds off for a long
      // stretch while the sender keeps offering a burst long enough to overflow the
      // queue, so the block has to stall its input until the results drain.
      load_filters(ID_W'($urandom), 29'h7FF, ID_W'($urandom), 29'h0, 29'h0, 29'h0,
                   3'b110);
      start_hold = 1'b1;
      repeat (20) issue_beat(random_beat(CMD_RECEIVE));
      issue_beat(random_beat(CMD_DISPATCH));
      run_random(30);

      req_bus.valid <= 1'b0;
      while (rx_path_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
